// File: hdl/voice_priority_top_k_selector_defines.svh
// Assertion macros for the voice priority top-k selector.
// No dependencies.
`ifndef VOICE_PRIORITY_TOP_K_SELECTOR_DEFINES_SVH
`define VOICE_PRIORITY_TOP_K_SELECTOR_DEFINES_SVH
`ifndef SYNTHESIS
`define VPS_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define VPS_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define VPS_ASSERT(label, clk, rst, prop, msg)
`define VPS_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// File: hdl/vps_pkg.sv
// Shared types and constants for the voice priority top-k selector.
// No dependencies.
package vps_pkg;
  localparam int SCORE_W = 32;
  localparam int KEY_W = 64;
  localparam int POS_W = 5;
  localparam int CNT_W = 6;
  localparam int QUO_W = 10;

  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic [KEY_W-1:0] key;
    logic [POS_W-1:0] pos;
  } entry_t;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DIV  = 5'b00010,
    ST_INS  = 5'b00100,
    ST_EMIT = 5'b01000,
    ST_NONE = 5'b10000
  } state_t;

  typedef enum logic [1:0] {
    CLS_EFFECT   = 2'd0,
    CLS_DIALOGUE = 2'd1,
    CLS_MUSIC    = 2'd2,
    CLS_AMBIENCE = 2'd3
  } sound_class_t;

  function automatic logic signed [SCORE_W-1:0] bias_of(input logic [1:0] cls);
    logic signed [SCORE_W-1:0] b;
    unique case (cls)
      CLS_DIALOGUE: b = 32'sd3000000;
      CLS_MUSIC: b = 32'sd2000000;
      CLS_AMBIENCE: b = 32'sd1000000;
      default: b = 32'sd0;
    endcase
    return b;
  endfunction
endpackage

// File: hdl/vps_divider.sv
// Restoring divider: floor(num*1000/den) for num <= den, one quotient bit per cycle.
// Depends on vps_pkg.
module vps_divider (
  input  logic clk,
  input  logic rst,
  input  logic go,
  input  logic [31:0] num,
  input  logic [31:0] den,
  output logic done,
  output logic [vps_pkg::QUO_W-1:0] quo
);
  logic [41:0] rem;
  logic [41:0] dvs;
  logic [3:0] cnt;
  logic busy;
  logic [42:0] diff;

  assign diff = {1'b0, rem} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        cnt <= 4'd9;
        rem <= 42'(num) * 42'd1000;
        dvs <= {den, 10'd0} >> 1;
        quo <= '0;
      end else if (busy) begin
        if (!diff[42]) begin
          rem <= diff[41:0];
        end
        quo <= {quo[vps_pkg::QUO_W-2:0], ~diff[42]};
        dvs <= dvs >> 1;
        if (cnt == 4'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 4'd1;
        end
      end
    end
  end
endmodule

// File: hdl/vps_cell.sv
// One sorted-list cell: keeps an entry, takes the new word or a neighbor's.
// Depends on vps_pkg.
module vps_cell (
  input  logic clk,
  input  logic rst,
  input  logic clr,
  input  logic ins,
  input  logic shift,
  input  vps_pkg::entry_t new_entry,
  input  vps_pkg::entry_t left_entry,
  input  logic left_valid,
  input  logic left_beats,
  input  vps_pkg::entry_t right_entry,
  input  logic right_valid,
  output vps_pkg::entry_t entry,
  output logic valid,
  output logic beats
);
  assign beats = !valid || (($signed(new_entry.score) != $signed(entry.score)) ?
                 ($signed(new_entry.score) > $signed(entry.score)) :
                 (new_entry.key < entry.key));

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      valid <= 1'b0;
    end else if (ins) begin
      if (beats) begin
        if (left_beats) begin
          entry <= left_entry;
          valid <= left_valid;
        end else begin
          entry <= new_entry;
          valid <= 1'b1;
        end
      end
    end else if (shift) begin
      entry <= right_entry;
      valid <= right_valid;
    end
  end
endmodule

// File: hdl/voice_priority_top_k_selector.sv
// Voice priority top-k selector: scoring, sorted cell chain, result emission.
// Depends on vps_pkg, vps_divider, vps_cell and the defines header.
// Scored candidate: setup, divider, insert before the next accept; culled: no divider.
// Once a run ends, its result words follow one per cycle.
// Synchronous active-high reset clears list, counts and sets max_voices to 32.
// The receiver cannot stall.
`include "voice_priority_top_k_selector_defines.svh"
module voice_priority_top_k_selector #(
  parameter int MAX_CANDIDATES = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic cfg_we,
  input  logic [5:0] cfg_data,
  input  logic signed [15:0] priority_req,
  input  logic [1:0] sound_class,
  input  logic is_spatial,
  input  logic is_looping,
  input  logic [31:0] distance,
  input  logic [31:0] max_distance,
  input  logic [63:0] tie_key,
  input  logic last,
  output logic result_strobe,
  output logic [4:0] voice_index,
  output logic index_valid,
  output logic [5:0] culled_count,
  output logic [5:0] rejected_count,
  output logic last_result
);
  localparam int N = MAX_CANDIDATES;
  localparam int AW = $clog2(N + 1);

  vps_pkg::state_t state;
  logic [5:0] max_voices;
  logic [AW-1:0] fill, arrivals;
  logic [5:0] culled;
  logic run_end;
  logic signed [31:0] base;
  logic ranged;
  logic [31:0] rng;
  logic [31:0] diffd;
  logic [63:0] key_r;
  logic [4:0] pos_r;
  logic div_go, div_done;
  logic [vps_pkg::QUO_W-1:0] quo;
  vps_pkg::entry_t new_entry;
  vps_pkg::entry_t ent [N];
  logic vld [N];
  logic bt [N];
  logic ins, shift, clr;
  logic [5:0] admitted, emit_k, rej;
  logic [5:0] arr6;
  logic [6:0] fill7, adm7;

  assign fill7 = 7'(fill);
  assign arr6 = 6'(arrivals);
  assign busy = (state != vps_pkg::ST_IDLE);
  assign shift = (state == vps_pkg::ST_EMIT);

  vps_divider u_div (
    .clk(clk), .rst(rst), .go(div_go), .num(diffd), .den(rng),
    .done(div_done), .quo(quo)
  );

  assign new_entry.score = base + (ranged ? 32'(quo) : 32'sd1000);
  assign new_entry.key = key_r;
  assign new_entry.pos = pos_r;

  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_cell
      vps_pkg::entry_t le, re;
      logic lv, lb, rv;
      if (g == 0) begin : g_head
        assign le = '0;
        assign lv = 1'b0;
        assign lb = 1'b0;
      end else begin : g_link_l
        assign le = ent[g-1];
        assign lv = vld[g-1];
        assign lb = bt[g-1];
      end
      if (g == N - 1) begin : g_tail
        assign re = '0;
        assign rv = 1'b0;
      end else begin : g_link_r
        assign re = ent[g+1];
        assign rv = vld[g+1];
      end
      vps_cell u_c (
        .clk(clk), .rst(rst), .clr(clr), .ins(ins), .shift(shift),
        .new_entry(new_entry), .left_entry(le), .left_valid(lv), .left_beats(lb),
        .right_entry(re), .right_valid(rv),
        .entry(ent[g]), .valid(vld[g]), .beats(bt[g])
      );
    end
  endgenerate

  always_comb begin
    if (max_voices == 6'd0) begin
      adm7 = 7'd0;
      rej = arr6;
    end else begin
      adm7 = (fill7 < {1'b0, max_voices}) ? fill7 : {1'b0, max_voices};
      rej = 6'(fill7 - adm7);
    end
    admitted = (adm7 > 7'd32) ? 6'd32 : 6'(adm7);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vps_pkg::ST_IDLE;
      max_voices <= 6'd32;
      fill <= '0;
      arrivals <= '0;
      culled <= '0;
      div_go <= 1'b0;
      ins <= 1'b0;
      clr <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      div_go <= 1'b0;
      ins <= 1'b0;
      clr <= 1'b0;
      result_strobe <= 1'b0;
      if (cfg_we) max_voices <= cfg_data;
      unique case (state)
        vps_pkg::ST_IDLE: begin
          if (start) begin
            pos_r <= 5'(arrivals);
            arrivals <= arrivals + AW'(1);
            run_end <= last || (32'(arrivals) + 32'd1 >= 32'(N));
            key_r <= tie_key;
            ranged <= is_spatial && (max_distance != 32'd0);
            rng <= max_distance;
            diffd <= max_distance - distance;
            base <= 32'(priority_req) * 32'sd10000 + vps_pkg::bias_of(sound_class)
                    - ((is_looping && sound_class == vps_pkg::CLS_EFFECT) ?
                       32'sd100 : 32'sd0);
            if (is_spatial && max_distance != 32'd0 && distance > max_distance) begin
              culled <= culled + 6'd1;
              state <= vps_pkg::ST_INS;
            end else begin
              div_go <= 1'b1;
              state <= vps_pkg::ST_DIV;
            end
          end
        end
        vps_pkg::ST_DIV: begin
          if (div_done) begin
            if (32'(fill) < 32'(N)) begin
              ins <= 1'b1;
              fill <= fill + AW'(1);
            end
            state <= vps_pkg::ST_INS;
          end
        end
        vps_pkg::ST_INS: begin
          if (!ins) begin
            if (!run_end) begin
              state <= vps_pkg::ST_IDLE;
            end else if (admitted == 6'd0) begin
              state <= vps_pkg::ST_NONE;
            end else begin
              emit_k <= 6'd0;
              state <= vps_pkg::ST_EMIT;
            end
          end
        end
        vps_pkg::ST_EMIT: begin
          result_strobe <= 1'b1;
          voice_index <= ent[0].pos;
          index_valid <= 1'b1;
          culled_count <= (max_voices == 6'd0) ? 6'd0 : culled;
          rejected_count <= rej;
          last_result <= (emit_k + 6'd1 == admitted);
          emit_k <= emit_k + 6'd1;
          if (emit_k + 6'd1 == admitted) begin
            clr <= 1'b1;
            fill <= '0;
            arrivals <= '0;
            culled <= '0;
            state <= vps_pkg::ST_IDLE;
          end
        end
        vps_pkg::ST_NONE: begin
          result_strobe <= 1'b1;
          voice_index <= 5'd0;
          index_valid <= 1'b0;
          culled_count <= (max_voices == 6'd0) ? 6'd0 : culled;
          rejected_count <= rej;
          last_result <= 1'b1;
          clr <= 1'b1;
          fill <= '0;
          arrivals <= '0;
          culled <= '0;
          state <= vps_pkg::ST_IDLE;
        end
        default: state <= vps_pkg::ST_IDLE;
      endcase
    end
  end

  `VPS_ASSERT(a_onehot, clk, rst, $onehot(state), "state not one-hot")
  `VPS_ASSERT(a_strobe_busy, clk, rst, result_strobe |-> $past(busy), "result while idle")
  `VPS_ASSERT(a_fill, clk, rst, (32'(fill) <= 32'(N)), "fill overflow")
endmodule

// File: verif/tb_top.sv
// Self-checking testbench for voice_priority_top_k_selector.
// Drives candidate runs (directed table, then random) and checks each result word
// against an in-bench ranking predictor. Depends on the RTL only.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RUN_MAX = 32;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_GAP = 20;
  localparam int N_RANDOM = 260;

  typedef enum logic [1:0] {
    CLS_EFFECT = 2'd0, CLS_DIALOGUE = 2'd1, CLS_MUSIC = 2'd2, CLS_AMBIENCE = 2'd3
  } snd_class_e;

  typedef struct {
    logic signed [15:0] prio;
    logic [1:0] cls;
    logic spatial;
    logic looping;
    logic [31:0] dst;
    logic [31:0] range;
    logic [63:0] key;
    logic lst;
  } cand_t;

  typedef struct {
    logic [4:0] idx;
    logic valid;
    logic [5:0] culled;
    logic [5:0] rejected;
    logic lst;
  } voice_word_t;

  typedef struct {
    bit is_cfg;
    logic [5:0] cfg_val;
    cand_t cand;
    bit chk;
    voice_word_t word;
  } row_t;

  logic clk, rst, start, busy, cfg_we;
  logic [5:0] cfg_data;
  logic signed [15:0] priority_req;
  logic [1:0] sound_class;
  logic is_spatial, is_looping, last;
  logic [31:0] distance, max_distance;
  logic [63:0] tie_key;
  logic result_strobe, index_valid, last_result;
  logic [4:0] voice_index;
  logic [5:0] culled_count, rejected_count;

  voice_priority_top_k_selector dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .priority_req(priority_req), .sound_class(sound_class),
    .is_spatial(is_spatial), .is_looping(is_looping),
    .distance(distance), .max_distance(max_distance),
    .tie_key(tie_key), .last(last),
    .result_strobe(result_strobe), .voice_index(voice_index),
    .index_valid(index_valid), .culled_count(culled_count),
    .rejected_count(rejected_count), .last_result(last_result)
  );

  // predictor state
  longint rank_score[RUN_MAX];
  logic [63:0] rank_key[RUN_MAX];
  int rank_pos[RUN_MAX];
  int rank_fill, cull_tally, arrivals;
  int voices_cfg;
  voice_word_t voice_words_q[$];

  int fails;
  int cycles = 0;
  bit idle_on;
  row_t rows[$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic report(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    fails++;
  endtask

  task automatic queue_word(input voice_word_t w);
    voice_words_q.insert(voice_words_q.size(), w);
  endtask

  task automatic add_row(input row_t r);
    rows.insert(rows.size(), r);
  endtask

  task automatic compare_word(input voice_word_t got, input voice_word_t want);
    if (got.idx !== want.idx || got.valid !== want.valid || got.culled !== want.culled ||
        got.rejected !== want.rejected || got.lst !== want.lst)
      report($sformatf("idx %0d/%0d valid %0b/%0b culled %0d/%0d rej %0d/%0d last %0b/%0b",
        got.idx, want.idx, got.valid, want.valid, got.culled, want.culled,
        got.rejected, want.rejected, got.lst, want.lst));
  endtask

  task automatic rank_candidate(input cand_t c);
    longint sc, prox;
    int at, pos;
    bit ranged;
    int admitted, culled, rejected;
    voice_word_t w;
    pos = arrivals;
    ranged = c.spatial && c.range != 0;
    arrivals++;
    if (ranged && c.dst > c.range) begin
      cull_tally++;
    end else begin
      prox = 1000;
      if (ranged)
        prox = longint'((64'(c.range - c.dst) * 64'd1000) / 64'(c.range));
      case (c.cls)
        CLS_DIALOGUE: sc = 3000000;
        CLS_MUSIC: sc = 2000000;
        CLS_AMBIENCE: sc = 1000000;
        default: sc = 0;
      endcase
      sc += longint'(c.prio) * 10000 + prox;
      if (c.looping && c.cls == CLS_EFFECT) sc -= 100;
      at = rank_fill;
      for (int j = 0; j < rank_fill; j++) begin
        if (sc > rank_score[j] || (sc == rank_score[j] && c.key < rank_key[j])) begin
          at = j;
          break;
        end
      end
      for (int j = rank_fill; j > at; j--) begin
        rank_score[j] = rank_score[j-1];
        rank_key[j] = rank_key[j-1];
        rank_pos[j] = rank_pos[j-1];
      end
      rank_score[at] = sc;
      rank_key[at] = c.key;
      rank_pos[at] = pos;
      rank_fill++;
    end
    if (!c.lst && arrivals < RUN_MAX) return;
    if (voices_cfg == 0) begin
      admitted = 0;
      culled = 0;
      rejected = arrivals;
    end else begin
      admitted = rank_fill < voices_cfg ? rank_fill : voices_cfg;
      culled = cull_tally;
      rejected = rank_fill - admitted;
    end
    w.culled = culled[5:0];
    w.rejected = rejected[5:0];
    if (admitted == 0) begin
      w.idx = '0;
      w.valid = 1'b0;
      w.lst = 1'b1;
      queue_word(w);
    end
    for (int k = 0; k < admitted; k++) begin
      w.idx = rank_pos[k][4:0];
      w.valid = 1'b1;
      w.lst = (k + 1 == admitted);
      queue_word(w);
    end
    rank_fill = 0;
    cull_tally = 0;
    arrivals = 0;
  endtask

  always @(posedge clk) begin
    voice_word_t got;
    if (!rst && result_strobe) begin
      got = '{voice_index, index_valid, culled_count, rejected_count, last_result};
      if (voice_words_q.size() == 0) report("result word with none expected");
      else compare_word(got, voice_words_q.pop_front());
    end
  end

  task automatic send(input cand_t c);
    int gap;
    gap = idle_on ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    priority_req = c.prio;
    sound_class = c.cls;
    is_spatial = c.spatial;
    is_looping = c.looping;
    distance = c.dst;
    max_distance = c.range;
    tie_key = c.key;
    last = c.lst;
    start = 1'b1;
    do @(posedge clk); while (busy);
    rank_candidate(c);
    @(negedge clk);
  endtask

  task automatic drain();
    start = 1'b0;
    while (voice_words_q.size() != 0) @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_voices(input logic [5:0] v);
    drain();
    cfg_we = 1'b1;
    cfg_data = v;
    @(negedge clk);
    cfg_we = 1'b0;
    voices_cfg = v;
  endtask

  function automatic cand_t mk(input logic signed [15:0] p, input logic [1:0] cl,
                               input logic sp, input logic lp, input logic [31:0] d,
                               input logic [31:0] r, input logic [63:0] k, input logic ls);
    cand_t c;
    c = '{p, cl, sp, lp, d, r, k, ls};
    return c;
  endfunction

  function automatic row_t item_row(input cand_t c);
    row_t r;
    r = '{1'b0, 6'd0, c, 1'b0, '{5'd0, 1'b0, 6'd0, 6'd0, 1'b0}};
    return r;
  endfunction

  function automatic row_t cfg_row(input logic [5:0] v);
    row_t r;
    r = item_row(mk(0, CLS_EFFECT, 0, 0, 0, 0, 0, 0));
    r.is_cfg = 1'b1;
    r.cfg_val = v;
    return r;
  endfunction

  function automatic row_t chk_row(input cand_t c, input voice_word_t w);
    row_t r;
    r = item_row(c);
    r.chk = 1'b1;
    r.word = w;
    return r;
  endfunction

  function automatic cand_t rand_cand(input bit lst);
    cand_t c;
    c.prio = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 4) - 2);
    c.cls = 2'($urandom_range(0, 3));
    c.spatial = 1'($urandom_range(0, 1));
    c.looping = 1'($urandom_range(0, 1));
    c.range = $urandom_range(0, 4) == 0 ? 32'd0 : $urandom;
    case ($urandom_range(0, 5))
      0: c.dst = $urandom;
      1: c.dst = c.range;
      2: c.dst = c.range + 32'd1;
      default: c.dst = $urandom_range(0, c.range);
    endcase
    c.key = $urandom_range(0, 2) == 0 ? 64'($urandom_range(0, 3)) : {$urandom, $urandom};
    c.lst = lst;
    return c;
  endfunction

  initial begin
    row_t rw;
    int sent, n;
    logic [5:0] vsel;
    bit lst_b;
    fails = 0;
    rst = 1'b1;
    start = 1'b0;
    cfg_we = 1'b0;
    cfg_data = '0;
    priority_req = '0;
    sound_class = '0;
    is_spatial = 1'b0;
    is_looping = 1'b0;
    distance = '0;
    max_distance = '0;
    tie_key = '0;
    last = 1'b0;
    idle_on = 1'b0;
    rank_fill = 0;
    cull_tally = 0;
    arrivals = 0;
    voices_cfg = 32;

    add_row(chk_row(mk(0, CLS_EFFECT, 0, 0, 0, 0, 0, 1), '{0, 1, 0, 0, 1}));
    add_row(chk_row(mk(5, CLS_MUSIC, 1, 0, 32'hFFFF_FFFF, 32'h10, 0, 1),
                    '{0, 0, 1, 0, 1}));
    add_row(item_row(mk(16'sh7FFF, CLS_DIALOGUE, 0, 0, 0, 0, '1, 0)));
    add_row(item_row(mk(16'sh8000, CLS_EFFECT, 0, 1, 0, 0, 0, 0)));
    add_row(item_row(mk(1, CLS_AMBIENCE, 1, 1, 32'h0001_0000, 32'h0001_0000, 7, 0)));
    add_row(item_row(mk(1, CLS_AMBIENCE, 1, 0, 32'hFFFF_FFFF, 0, 7, 0)));
    add_row(item_row(mk(1, CLS_AMBIENCE, 1, 0, 0, 32'hFFFF_FFFF, 3, 0)));
    add_row(item_row(mk(1, CLS_AMBIENCE, 0, 0, 5, 9, 3, 0)));
    add_row(item_row(mk(0, CLS_EFFECT, 1, 1, 32'h8000_0000, 32'h7FFF_FFFF, 1, 0)));
    add_row(item_row(mk(0, CLS_EFFECT, 0, 1, 0, 0, 1, 1)));
    add_row(cfg_row(6'd0));
    add_row(item_row(mk(3, CLS_MUSIC, 0, 0, 0, 0, 0, 0)));
    add_row(item_row(mk(3, CLS_MUSIC, 1, 0, 20, 10, 0, 0)));
    add_row(chk_row(mk(3, CLS_MUSIC, 0, 0, 0, 0, 0, 1), '{0, 0, 0, 3, 1}));
    add_row(cfg_row(6'd1));
    add_row(item_row(mk(-1, CLS_DIALOGUE, 0, 0, 0, 0, 2, 0)));
    add_row(item_row(mk(2, CLS_EFFECT, 0, 0, 0, 0, 2, 0)));
    add_row(item_row(mk(-1, CLS_DIALOGUE, 0, 0, 0, 0, 1, 1)));
    add_row(cfg_row(6'd63));
    add_row(item_row(mk(9, CLS_MUSIC, 0, 1, 0, 0, 4, 0)));
    add_row(item_row(mk(9, CLS_MUSIC, 0, 0, 0, 0, 4, 1)));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (rows[i]) begin
      rw = rows[i];
      if (rw.is_cfg) begin
        set_voices(rw.cfg_val);
      end else begin
        send(rw.cand);
        if (rw.chk) compare_word(voice_words_q[$], rw.word);
      end
    end

    sent = 0;
    while (sent < N_RANDOM) begin
      case ($urandom_range(0, 5))
        0: vsel = 6'd0;
        1: vsel = 6'd1;
        2: vsel = 6'd32;
        3: vsel = 6'd63;
        default: vsel = 6'($urandom_range(1, 40));
      endcase
      set_voices(vsel);
      repeat ($urandom_range(2, 5)) begin
        if (sent < N_RANDOM) begin
          idle_on = $urandom_range(0, 3) != 0;
          n = $urandom_range(0, 7) == 0 ? RUN_MAX : $urandom_range(1, 8);
          if (n > N_RANDOM - sent) n = N_RANDOM - sent;
          for (int i = 0; i < n; i++) begin
            lst_b = (i == n - 1) && (n != RUN_MAX || $urandom_range(0, 1) == 1);
            send(rand_cand(lst_b));
          end
          sent += n;
        end
      end
    end

    drain();
    if (fails == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end
endmodule
